FILE: rtl/core/bds_pkg.sv
// Shared types, constants and helpers for the 2x2 box downsampler.
// Used by every module in rtl/core; depends on nothing else.
package bds_pkg;

   // Default for the top-level line store size parameter
   localparam int MAX_SOURCE_WIDTH_DEFAULT = 4096;

   // Job queue between the front and the back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Configuration register map, indexed by paddr[3:2]
   localparam int CSR_ADDR_WIDTH = 4;
   localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_PIXEL_FORMAT  = 2'd2;

   // Register reset values
   localparam logic [12:0] SOURCE_WIDTH_RESET  = 13'd4096;
   localparam logic [15:0] SOURCE_HEIGHT_RESET = 16'd4096;
   localparam logic        PIXEL_FORMAT_RESET  = 1'b0;

   // Pixel format codes
   localparam logic FORMAT_ARGB = 1'b0;
   localparam logic FORMAT_RGB  = 1'b1;

   typedef struct packed {
      logic [7:0] alpha_in;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_data_type;

   typedef struct packed {
      logic [7:0] alpha_out;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       row_end;
      logic       frame_end;
   } rsp_data_type;

   // Four 9-bit channel sums, index 3 is alpha, index 0 is blue
   typedef logic [3:0][8:0] pair_sum_type;

   // Work handed from the front to the back end
   typedef struct packed {
      pair_sum_type above_sum;
      pair_sum_type pair_sum;
      logic         row_end;
      logic         frame_end;
   } job_type;

   // Address bits for a store of the given depth, at least one
   function automatic int addr_bits(input int depth);
      int bits;
      bits = $clog2(depth);
      return (bits < 1) ? 1 : bits;
   endfunction

endpackage

FILE: rtl/core/bds_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Uses bds_pkg for address sizing.
module bds_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 2048
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [bds_pkg::addr_bits(DEPTH)-1:0]     wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [bds_pkg::addr_bits(DEPTH)-1:0]     rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bds_front.sv
// Front end: pixel position tracking, pair accumulation and line store access.
// Depends on bds_pkg and bds_ram; emits jobs into the queue.
module bds_front #(
   parameter int MAX_SOURCE_WIDTH = bds_pkg::MAX_SOURCE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bds_pkg::req_data_type         req_data,
   input  logic [12:0]                   source_width,
   input  logic [15:0]                   source_height,
   input  logic                          pixel_format,
   input  logic [bds_pkg::QUEUE_CW-1:0]  queue_count,
   output logic                          push,
   output bds_pkg::job_type              push_job
);

   localparam int CW    = $clog2(MAX_SOURCE_WIDTH);
   localparam int EW    = (CW + 1 > 13) ? CW + 1 : 13;
   localparam int DEPTH = MAX_SOURCE_WIDTH / 2;
   localparam int AW    = bds_pkg::addr_bits(DEPTH);

   logic [CW-1:0]              col_ff, col_in;
   logic [15:0]                row_ff, row_in;
   logic [31:0]                first_ff, first_in;
   logic                       s1_valid_ff, s1_valid_in;
   bds_pkg::pair_sum_type      s1_pair_ff;
   logic                       s1_row_end_ff, s1_frame_end_ff;

   logic                       accept;
   logic [EW-1:0]              width_ext, eff_width, col_ext, col_next;
   logic [15:0]                eff_height;
   logic [16:0]                row_next;
   logic                       in_frame;
   logic [3:0][7:0]            pixel, first_pixel;
   bds_pkg::pair_sum_type      pair;
   logic [CW-1:0]              half_col;
   logic [AW-1:0]              line_addr;
   logic                       wr_en, rd_en;
   logic                       row_end, frame_end;
   logic [35:0]                above;

   // Clamp the configured frame size to what the line store supports
   always_comb begin
      width_ext = EW'(source_width);
      eff_width = width_ext;
      if (width_ext == '0) begin
         eff_width = EW'(1);
      end else if (width_ext > EW'(MAX_SOURCE_WIDTH)) begin
         eff_width = EW'(MAX_SOURCE_WIDTH);
      end
      eff_height = (source_height == 16'd0) ? 16'd1 : source_height;
   end

   // Hold off new pixels while the queue has no room for one more job
   assign req_stall = ({1'b0, queue_count} + (bds_pkg::QUEUE_CW + 1)'(s1_valid_ff))
                      >= (bds_pkg::QUEUE_CW + 1)'(bds_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   // Classify the pixel by its position
   assign col_ext  = EW'(col_ff);
   assign in_frame = (col_ext < eff_width) && (row_ff < eff_height);
   assign half_col = col_ff >> 1;
   assign line_addr = half_col[AW-1:0];
   assign wr_en    = accept && in_frame && col_ff[0] && !row_ff[0];
   assign rd_en    = accept && in_frame && col_ff[0] && row_ff[0];
   assign row_end  = (EW'(half_col) + EW'(1)) == (eff_width >> 1);
   assign frame_end = row_end && (({1'b0, row_ff[15:1]} + 16'd1) == (eff_height >> 1));

   // Form the pixel and add it to the waiting even-column pixel
   always_comb begin
      pixel[3] = (pixel_format == bds_pkg::FORMAT_RGB) ? 8'hFF : req_data.alpha_in;
      pixel[2] = req_data.red_in;
      pixel[1] = req_data.green_in;
      pixel[0] = req_data.blue_in;
      first_pixel = first_ff;
      for (int k = 0; k < 4; k++) begin
         pair[k] = 9'(first_pixel[k]) + 9'(pixel[k]);
      end
   end

   // Advance column and row, wrap at row and frame end
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      first_in = first_ff;
      col_next = col_ext + EW'(1);
      row_next = {1'b0, row_ff} + 17'd1;
      if (accept) begin
         if (in_frame && !col_ff[0]) begin
            first_in = pixel;
         end
         if (col_next >= eff_width) begin
            col_in = '0;
            row_in = (row_next >= {1'b0, eff_height}) ? 16'd0 : row_next[15:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   assign s1_valid_in = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         first_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         first_ff    <= first_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Hold the odd-row pair alongside the line store read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_pair_ff      <= pair;
         s1_row_end_ff   <= row_end;
         s1_frame_end_ff <= frame_end;
      end
   end

   // Line store of even-row pair sums
   bds_ram #(
      .WIDTH (36),
      .DEPTH (DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (line_addr),
      .wr_data (pair),
      .rd_en   (rd_en),
      .rd_addr (line_addr),
      .rd_data (above)
   );

   // Hand the combined job to the queue
   assign push                = s1_valid_ff;
   assign push_job.above_sum  = above;
   assign push_job.pair_sum   = s1_pair_ff;
   assign push_job.row_end    = s1_row_end_ff;
   assign push_job.frame_end  = s1_frame_end_ff;

   // Credit accounting never promises more than the queue holds
   a_credit: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, queue_count} + (bds_pkg::QUEUE_CW + 1)'(s1_valid_ff))
         <= (bds_pkg::QUEUE_CW + 1)'(bds_pkg::QUEUE_DEPTH))
      else $error("front: jobs in flight exceed queue depth");

   // A pixel either writes or reads the line store, never both
   a_line_port: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("front: line store written and read by one pixel");

endmodule

FILE: rtl/core/bds_queue.sv
// Short job queue that decouples the front end from the back end.
// Depends on bds_pkg for the job type and depth.
module bds_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  bds_pkg::job_type              push_job,
   input  logic                          pop,
   output bds_pkg::job_type              head_job,
   output logic                          empty,
   output logic [bds_pkg::QUEUE_CW-1:0]  count
);

   bds_pkg::job_type                 slot_ff [bds_pkg::QUEUE_DEPTH];
   logic [bds_pkg::QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bds_pkg::QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bds_pkg::QUEUE_CW-1:0]     count_ff, count_in;
   logic                             full;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == bds_pkg::QUEUE_CW'(bds_pkg::QUEUE_DEPTH));
   assign count    = count_ff;
   assign head_job = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + bds_pkg::QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + bds_pkg::QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + bds_pkg::QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - bds_pkg::QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming job
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue: push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue: pop while empty");

endmodule

FILE: rtl/core/bds_back.sv
// Back end: combines stored and current pair sums, rounds, and drives results.
// Depends on bds_pkg; pulls jobs from bds_queue.
module bds_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    queue_empty,
   input  bds_pkg::job_type        head_job,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bds_pkg::rsp_data_type   rsp_data
);

   logic                    out_valid_ff, out_valid_in;
   bds_pkg::rsp_data_type   out_data_ff;
   bds_pkg::rsp_data_type   result;
   logic [3:0][7:0]         mean;
   logic [9:0]              block_sum;

   // Rounded mean of the four samples per channel
   always_comb begin
      mean = '0;
      for (int k = 0; k < 4; k++) begin
         block_sum = 10'(head_job.above_sum[k]) + 10'(head_job.pair_sum[k]) + 10'd2;
         mean[k]   = block_sum[9:2];
      end
      result.alpha_out = mean[3];
      result.red_out   = mean[2];
      result.green_out = mean[1];
      result.blue_out  = mean[0];
      result.row_end   = head_job.row_end;
      result.frame_end = head_job.frame_end;
   end

   // Refill the output register when it is empty or being taken
   assign pop = !queue_empty && (!out_valid_ff || !rsp_stall);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: rtl/core/box_downsample_2x2_argb_unit.sv
// 2x2 box-filter downsampler for a raster ARGB pixel stream (top level).
// Depends on bds_pkg, bds_front, bds_queue, bds_back and bds_ram.
//
// Usage:
//   Source pixels enter on req_valid / req_stall / req_data in raster order,
//   one transfer per pixel. Each 2x2 block becomes one averaged pixel on
//   rsp_valid / rsp_stall / rsp_data, with row_end and frame_end marking the
//   last pixel of an output row and of the frame. An odd last column or row
//   gives no output. Frame size and pixel format are set through the APB
//   port (width at 0x0, height at 0x4, format at 0x8) while the block idles.
//   Throughput: one source pixel per cycle while req_stall is low, one
//   result per four pixels. A result passes from the odd-row, odd-column
//   pixel that completes its block through the registered line store
//   read, a job queue slot and the output register.
//   A four-entry job queue and the output register take up receiver stalls;
//   req_stall rises once queued jobs plus the one in flight reach four.
//   Reset clears position counters, queue and output valid and restores
//   width 4096, height 4096, ARGB. The line store is not cleared; every
//   entry is written on an even row before it is read on the next odd row.
module box_downsample_2x2_argb_unit #(
   parameter int MAX_SOURCE_WIDTH = bds_pkg::MAX_SOURCE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bds_pkg::req_data_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bds_pkg::rsp_data_type               rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bds_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic [12:0]                     width_ff;
   logic [15:0]                     height_ff;
   logic                            format_ff;
   logic                            csr_write;
   logic                            push, pop, queue_empty;
   logic [bds_pkg::QUEUE_CW-1:0]    queue_count;
   bds_pkg::job_type                push_job, head_job;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bds_pkg::SOURCE_WIDTH_RESET;
         height_ff <= bds_pkg::SOURCE_HEIGHT_RESET;
         format_ff <= bds_pkg::PIXEL_FORMAT_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            bds_pkg::REG_SOURCE_WIDTH:  width_ff  <= pwdata[12:0];
            bds_pkg::REG_SOURCE_HEIGHT: height_ff <= pwdata[15:0];
            bds_pkg::REG_PIXEL_FORMAT:  format_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read-back
   always_comb begin
      case (paddr[3:2])
         bds_pkg::REG_SOURCE_WIDTH:  prdata = {19'd0, width_ff};
         bds_pkg::REG_SOURCE_HEIGHT: prdata = {16'd0, height_ff};
         bds_pkg::REG_PIXEL_FORMAT:  prdata = {31'd0, format_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   bds_front #(
      .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .source_width  (width_ff),
      .source_height (height_ff),
      .pixel_format  (format_ff),
      .queue_count   (queue_count),
      .push          (push),
      .push_job      (push_job)
   );

   bds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .count    (queue_count)
   );

   bds_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: tb/tb_box_downsample_2x2_argb_unit.sv
// Self-checking testbench for the 2x2 box downsampler: raster pixels in, averaged pixels out.
// Depends on bds_pkg and box_downsample_2x2_argb_unit; predicts every output pixel itself.
module tb_box_downsample_2x2_argb_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH     = bds_pkg::MAX_SOURCE_WIDTH_DEFAULT;
   localparam int LINE_DEPTH    = MAX_WIDTH / 2;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int MAX_REPORTS   = 100;

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   bds_pkg::req_data_type               req_data  = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   bds_pkg::rsp_data_type               rsp_data;
   logic                                psel      = 1'b0;
   logic                                penable   = 1'b0;
   logic                                pwrite    = 1'b0;
   logic [bds_pkg::CSR_ADDR_WIDTH-1:0]  paddr     = '0;
   logic [31:0]                         pwdata    = '0;
   logic [31:0]                         prdata;
   logic                                pready;

   // Predictor state: register copies, raster position, pending pair and line of pair sums
   logic [12:0]            cfg_width  = bds_pkg::SOURCE_WIDTH_RESET;
   logic [15:0]            cfg_height = bds_pkg::SOURCE_HEIGHT_RESET;
   logic                   cfg_format = bds_pkg::PIXEL_FORMAT_RESET;
   logic [11:0]            col_pos    = '0;
   logic [15:0]            row_pos    = '0;
   logic [31:0]            pair_first = '0;
   bds_pkg::pair_sum_type  pair_line [LINE_DEPTH];
   bds_pkg::rsp_data_type  expected_pixels [$];

   int errors        = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   box_downsample_2x2_argb_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #4 clock = ~clock;

   // Rounded mean of four samples given as two pair sums
   function automatic logic [7:0] block_mean(input logic [8:0] upper, input logic [8:0] lower);
      logic [9:0] total;
      total = 10'(upper) + 10'(lower) + 10'd2;
      return total[9:2];
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Advance the raster position by one accepted pixel and queue any output pixel
   task automatic downsample_pixel(input bds_pkg::req_data_type pixel);
      int unsigned            w, h, c, r, idx;
      int                     k;
      logic [31:0]            px;
      bds_pkg::pair_sum_type  pair, above;
      bds_pkg::rsp_data_type  result;
      w = (cfg_width == 0) ? 1 : cfg_width;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = (cfg_height == 0) ? 1 : cfg_height;
      c = col_pos;
      r = row_pos;
      px = pixel;
      if (cfg_format == bds_pkg::FORMAT_RGB) px[31:24] = 8'hFF;
      if (c < w && r < h) begin
         if (!c[0]) begin
            pair_first = px;
         end else begin
            idx = (c >> 1) % LINE_DEPTH;
            for (k = 0; k < 4; k++)
               pair[k] = 9'(pair_first[8*k +: 8]) + 9'(px[8*k +: 8]);
            if (!r[0]) begin
               pair_line[idx] = pair;
            end else begin
               above = pair_line[idx];
               result.alpha_out = block_mean(above[3], pair[3]);
               result.red_out   = block_mean(above[2], pair[2]);
               result.green_out = block_mean(above[1], pair[1]);
               result.blue_out  = block_mean(above[0], pair[0]);
               result.row_end   = ((c >> 1) + 1 == (w >> 1));
               result.frame_end = result.row_end && ((r >> 1) + 1 == (h >> 1));
               expected_pixels.push_back(result);
            end
         end
      end
      // wrap at row and frame boundaries
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c[11:0];
      row_pos = r[15:0];
   endtask

   // Offer one pixel, with random gaps ahead of it, and hold it until the transfer
   task automatic send_pixel(input bds_pkg::req_data_type pixel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pixel;
      do @(posedge clock); while (req_stall);
      downsample_pixel(pixel);
   endtask

   // Drop valid, wait for every queued output pixel, then let the pipeline settle
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (index)
         bds_pkg::REG_SOURCE_WIDTH:  cfg_width  = value[12:0];
         bds_pkg::REG_SOURCE_HEIGHT: cfg_height = value[15:0];
         bds_pkg::REG_PIXEL_FORMAT:  cfg_format = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [1:0] index, output logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Reset values, then the top of each register's range, read back
   task automatic test_register_access();
      logic [31:0] got;
      csr_read(bds_pkg::REG_SOURCE_WIDTH, got);
      check_field("source_width reset", {19'd0, bds_pkg::SOURCE_WIDTH_RESET}, got);
      csr_read(bds_pkg::REG_SOURCE_HEIGHT, got);
      check_field("source_height reset", {16'd0, bds_pkg::SOURCE_HEIGHT_RESET}, got);
      csr_read(bds_pkg::REG_PIXEL_FORMAT, got);
      check_field("pixel_format reset", {31'd0, bds_pkg::PIXEL_FORMAT_RESET}, got);
      csr_write(bds_pkg::REG_SOURCE_WIDTH, 32'd8191);
      csr_read(bds_pkg::REG_SOURCE_WIDTH, got);
      check_field("source_width", 32'd8191, got);
      csr_write(bds_pkg::REG_SOURCE_HEIGHT, 32'd65535);
      csr_read(bds_pkg::REG_SOURCE_HEIGHT, got);
      check_field("source_height", 32'd65535, got);
      csr_write(bds_pkg::REG_PIXEL_FORMAT, {31'd0, bds_pkg::FORMAT_RGB});
      csr_read(bds_pkg::REG_PIXEL_FORMAT, got);
      check_field("pixel_format", {31'd0, bds_pkg::FORMAT_RGB}, got);
   endtask

   // 2x2 frames: channel extremes, rounding of sums 1, 2, 3 and 1019, alpha forced in RGB
   task automatic test_block_means();
      csr_write(bds_pkg::REG_SOURCE_WIDTH, 32'd2);
      csr_write(bds_pkg::REG_SOURCE_HEIGHT, 32'd2);
      csr_write(bds_pkg::REG_PIXEL_FORMAT, {31'd0, bds_pkg::FORMAT_ARGB});
      repeat (4) send_pixel(32'h0000_0000);
      repeat (4) send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_00FF);
      send_pixel(32'h0000_01FF);
      send_pixel(32'h0001_01FF);
      send_pixel(32'h0101_01FE);
      wait_for_drain();
      csr_write(bds_pkg::REG_PIXEL_FORMAT, {31'd0, bds_pkg::FORMAT_RGB});
      send_pixel(32'h0055_AA55);
      send_pixel(32'hFFAA_55AA);
      send_pixel(32'h00AA_55AA);
      send_pixel(32'hFF55_AA55);
      wait_for_drain();
   endtask

   // Odd last row and column dropped; zero width and height act as one
   task automatic test_dropped_edges();
      csr_write(bds_pkg::REG_SOURCE_WIDTH, 32'd3);
      csr_write(bds_pkg::REG_SOURCE_HEIGHT, 32'd3);
      csr_write(bds_pkg::REG_PIXEL_FORMAT, {31'd0, bds_pkg::FORMAT_ARGB});
      repeat (9) send_pixel(bds_pkg::req_data_type'($urandom()));
      wait_for_drain();
      csr_write(bds_pkg::REG_SOURCE_WIDTH, 32'd0);
      csr_write(bds_pkg::REG_SOURCE_HEIGHT, 32'd0);
      repeat (2) send_pixel(bds_pkg::req_data_type'($urandom()));
      wait_for_drain();
   endtask

   // Fill the line entries that later frames reach, then send the first 64 pixels of a row of an oversized width
   task automatic test_full_width();
      csr_write(bds_pkg::REG_SOURCE_WIDTH, 32'd64);
      csr_write(bds_pkg::REG_SOURCE_HEIGHT, 32'd2);
      repeat (128) send_pixel(bds_pkg::req_data_type'($urandom()));
      wait_for_drain();
      csr_write(bds_pkg::REG_SOURCE_WIDTH, 32'd8191);
      repeat (64) send_pixel(bds_pkg::req_data_type'($urandom()));
      wait_for_drain();
   endtask

   // Size changes with the raster position in mid-frame and beyond the new bounds
   task automatic test_midframe_change();
      csr_write(bds_pkg::REG_SOURCE_WIDTH, 32'd4);
      csr_write(bds_pkg::REG_SOURCE_HEIGHT, 32'd65535);
      repeat (14) send_pixel(bds_pkg::req_data_type'($urandom()));
      wait_for_drain();
      csr_write(bds_pkg::REG_SOURCE_HEIGHT, 32'd2);
      repeat (8) send_pixel(bds_pkg::req_data_type'($urandom()));
      wait_for_drain();
      csr_write(bds_pkg::REG_SOURCE_WIDTH, 32'd8);
      repeat (10) send_pixel(bds_pkg::req_data_type'($urandom()));
      wait_for_drain();
      csr_write(bds_pkg::REG_SOURCE_WIDTH, 32'd2);
      repeat (7) send_pixel(bds_pkg::req_data_type'($urandom()));
      wait_for_drain();
   endtask

   // Long receiver hold-off while pixels keep coming, so the block backs up
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      csr_write(bds_pkg::REG_SOURCE_WIDTH, 32'd16);
      csr_write(bds_pkg::REG_SOURCE_HEIGHT, 32'd8);
      csr_write(bds_pkg::REG_PIXEL_FORMAT, {31'd0, bds_pkg::FORMAT_ARGB});
      hold_requests++;
      repeat (128) send_pixel(bds_pkg::req_data_type'($urandom()));
      wait_for_drain();
   endtask

   // Random sizes and formats, mostly whole frames, some cut short
   task automatic test_random_frames(input int send_pct, input int rsp_pct, input int budget);
      int sent, total, w, h;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      sent = 0;
      while (sent < budget) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
         h = $urandom_range(0, 6);
         wait_for_drain();
         csr_write(bds_pkg::REG_SOURCE_WIDTH, 32'(w));
         csr_write(bds_pkg::REG_SOURCE_HEIGHT, 32'(h));
         csr_write(bds_pkg::REG_PIXEL_FORMAT, 32'($urandom_range(1)));
         total = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * $urandom_range(1, 2);
         if ($urandom_range(4) == 0) total = $urandom_range(1, total);
         repeat (total) send_pixel(bds_pkg::req_data_type'($urandom()));
         sent += total;
      end
      wait_for_drain();
   endtask

   // Receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Compare each output transfer with the oldest expected pixel
   always @(posedge clock) begin
      bds_pkg::rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t ns: output pixel with none expected, expected none, actual %h",
                        $time, rsp_data);
         end else begin
            want = expected_pixels.pop_front();
            check_field("alpha_out", want.alpha_out, rsp_data.alpha_out);
            check_field("red_out", want.red_out, rsp_data.red_out);
            check_field("green_out", want.green_out, rsp_data.green_out);
            check_field("blue_out", want.blue_out, rsp_data.blue_out);
            check_field("row_end", want.row_end, rsp_data.row_end);
            check_field("frame_end", want.frame_end, rsp_data.frame_end);
         end
      end
   end

   // Watchdog: end the run after too long without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 8;
      rsp_idle_pct  = 62;
      test_register_access();
      test_block_means();
      test_dropped_edges();
      test_full_width();
      test_midframe_change();
      test_backpressure();
      test_random_frames(8, 62, 230);
      test_random_frames(62, 8, 230);
      test_random_frames(0, 0, 230);
      wait_for_drain();
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
